// File: hdl/mwde_pkg.sv
// Shared types, constants and sequencer states for the median width distance estimator.
// No dependencies; every other file depends on this package.
package mwde_pkg;

   localparam int WINDOW_LEN = 8;
   localparam int SLOT_W     = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
   localparam int CNT_W      = $clog2(WINDOW_LEN + 1);
   localparam int WIDTH_W    = 11;
   localparam int DIST_W     = 16;
   localparam int QUO_W      = 15;
   localparam int BIT_W      = $clog2(QUO_W);

   typedef logic [WIDTH_W-1:0]       width_type;
   typedef logic signed [DIST_W-1:0] dist_type;
   typedef logic [SLOT_W-1:0]        slot_type;
   typedef logic [CNT_W-1:0]         cnt_type;
   typedef logic [QUO_W-1:0]         quo_type;
   typedef logic [BIT_W-1:0]         bit_type;

   localparam cnt_type   MEDIAN_RANK = CNT_W'(WINDOW_LEN >> 1);
   localparam slot_type  LAST_SLOT   = SLOT_W'(WINDOW_LEN - 1);

   localparam width_type SMALL_WIDTH = 11'd40;
   localparam width_type LIMIT_WIDTH = 11'd350;
   localparam quo_type   DIST_NUMER  = 15'd21189;
   localparam bit_type   NUMER_TOP   = BIT_W'(QUO_W - 1);
   localparam dist_type  DIST_OFFSET = 16'sd20;
   localparam dist_type  SMALL_DIST  = 16'sd520;
   localparam dist_type  FAR_DIST    = 16'sd50;
   localparam dist_type  NO_DIST     = -16'sd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RANK,
      ST_DIVIDE,
      ST_ADJUST,
      ST_FINISH
   } state_type;

endpackage

// File: hdl/mwde_if.sv
// Request and response channel interfaces of the median width distance estimator.
// Depends on mwde_pkg for the payload types.
interface mwde_req_if;
   logic                 valid;
   logic                 ready;
   logic                 detected;
   mwde_pkg::width_type  box_width;

   modport source (output valid, output detected, output box_width, input ready);
   modport sink   (input valid, input detected, input box_width, output ready);
endinterface

interface mwde_rsp_if;
   logic                 valid;
   logic                 ready;
   mwde_pkg::dist_type   distance;

   modport source (output valid, output distance, input ready);
   modport sink   (input valid, input distance, output ready);
endinterface

// File: hdl/median_width_distance_estimate_core.sv
// Median width distance estimator: running window of box widths, rank scan, restoring divider.
// Depends on mwde_pkg and the channel interfaces in mwde_if.sv.
//
// Each request writes its width (zero when nothing was detected) over the oldest of the
// last eight widths, then returns one distance. A request is accepted, then the rank counter
// scans window entries one at a time until it finds the upper median (at most eight); the
// restoring divider takes fifteen one-bit steps and the offset is subtracted when the median
// lies in 1..349 and is not 40, and finally the response register is loaded. The block
// is ready only between requests; a finished response waits in its register until taken.
module median_width_distance_estimate_core (
   input  logic        clock,
   input  logic        reset,
   mwde_req_if.sink    req_chan,
   mwde_rsp_if.source  rsp_chan
);
   import mwde_pkg::*;

   state_type state_ff, state_in;

   width_type window_ff [WINDOW_LEN];
   slot_type  slot_ff, slot_in;
   slot_type  cand_ff, cand_in;
   width_type median_ff, median_in;
   width_type rem_ff, rem_in;
   quo_type   quo_ff, quo_in;
   bit_type   bit_ff, bit_in;
   dist_type  result_ff, result_in;
   logic      rsp_valid_ff, rsp_valid_in;
   dist_type  rsp_dist_ff, rsp_dist_in;

   logic      req_take;
   width_type cand_width;
   cnt_type   lt_cnt, le_cnt;
   logic      rank_hit;
   width_type trial;
   logic      trial_ge;

   assign req_chan.ready    = (state_ff == ST_IDLE);
   assign req_take          = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.distance = rsp_dist_ff;

   // rank of the current candidate within the window
   always_comb begin
      cand_width = window_ff[cand_ff];
      lt_cnt     = '0;
      le_cnt     = '0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
         if (window_ff[i] < cand_width) begin
            lt_cnt = lt_cnt + CNT_W'(1);
         end
         if (window_ff[i] <= cand_width) begin
            le_cnt = le_cnt + CNT_W'(1);
         end
      end
      rank_hit = (lt_cnt <= MEDIAN_RANK) && (le_cnt > MEDIAN_RANK);
   end

   assign trial    = {rem_ff[WIDTH_W-2:0], DIST_NUMER[bit_ff]};
   assign trial_ge = (trial >= median_ff);

   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      cand_in      = cand_ff;
      median_in    = median_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      bit_in       = bit_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_dist_in  = rsp_dist_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               slot_in  = (slot_ff == LAST_SLOT) ? '0 : slot_ff + SLOT_W'(1);
               cand_in  = '0;
               state_in = ST_RANK;
            end
         end
         ST_RANK: begin
            if (rank_hit) begin
               median_in = cand_width;
               rem_in    = '0;
               quo_in    = '0;
               bit_in    = NUMER_TOP;
               if (cand_width == '0) begin
                  result_in = NO_DIST;
                  state_in  = ST_FINISH;
               end else if (cand_width == SMALL_WIDTH) begin
                  result_in = SMALL_DIST;
                  state_in  = ST_FINISH;
               end else if (cand_width >= LIMIT_WIDTH) begin
                  result_in = FAR_DIST;
                  state_in  = ST_FINISH;
               end else begin
                  state_in  = ST_DIVIDE;
               end
            end else begin
               cand_in = (cand_ff == LAST_SLOT) ? '0 : cand_ff + SLOT_W'(1);
            end
         end
         ST_DIVIDE: begin
            rem_in = trial_ge ? trial - median_ff : trial;
            quo_in = {quo_ff[QUO_W-2:0], trial_ge};
            bit_in = bit_ff - BIT_W'(1);
            if (bit_ff == '0) begin
               state_in = ST_ADJUST;
            end
         end
         ST_ADJUST: begin
            result_in = dist_type'({1'b0, quo_ff}) - DIST_OFFSET;
            state_in  = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_dist_in  = result_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < WINDOW_LEN; i++) begin
            window_ff[i] <= '0;
         end
      end else begin
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_take) begin
            window_ff[slot_ff] <= req_chan.detected ? req_chan.box_width : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cand_ff     <= cand_in;
      median_ff   <= median_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      bit_ff      <= bit_in;
      result_ff   <= result_in;
      rsp_dist_ff <= rsp_dist_in;
   end

endmodule

// File: hdl/mwde_checker.sv
// Port-level checks for the median width distance estimator, bound to the top level.
// Depends on mwde_pkg and median_width_distance_estimate_core.
module mwde_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input mwde_pkg::dist_type  rsp_distance
);
   import mwde_pkg::*;

   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_busy_after_request : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while still working");

   a_distance_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_distance >= NO_DIST) && (rsp_distance <= 16'sd21169)
                    && (rsp_distance != 16'sd0))
      else $error("distance out of range");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_distance))
      else $error("stalled response changed");

endmodule

bind median_width_distance_estimate_core mwde_checker u_mwde_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_distance (rsp_chan.distance)
);

// File: tb/median_width_distance_estimate_core_test.sv
// Self-checking testbench for median_width_distance_estimate_core with back-pressure.
// Depends on mwde_pkg and the channel interfaces in mwde_if.sv.
// Expected distances come from a running-window median predictor kept inside the bench.
module median_width_distance_estimate_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import mwde_pkg::*;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_OFF_LEN = 300;
   localparam int EXP_DEPTH    = 64;

   logic clock;
   logic reset;

   mwde_req_if req_chan ();
   mwde_rsp_if rsp_chan ();

   median_width_distance_estimate_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   width_type width_hist [WINDOW_LEN];
   slot_type  next_slot;
   dist_type  expected_distances [EXP_DEPTH];

   int req_idle_pct;
   int rsp_idle_pct;
   int hold_req_count = 0;
   int hold_seen;
   int hold_left;
   int cycle_count    = 0;
   int mismatch_count = 0;
   int sent_count     = 0;
   int checked_count  = 0;
   int exp_wr_count   = 0;
   int exp_rd_count   = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
   end

   function automatic width_type window_median();
      width_type sorted_w [WINDOW_LEN];
      width_type tmp;
      sorted_w = width_hist;
      for (int i = 0; i < WINDOW_LEN - 1; i++) begin
         for (int j = 0; j < WINDOW_LEN - 1 - i; j++) begin
            if (sorted_w[j] > sorted_w[j+1]) begin
               tmp           = sorted_w[j];
               sorted_w[j]   = sorted_w[j+1];
               sorted_w[j+1] = tmp;
            end
         end
      end
      return sorted_w[WINDOW_LEN >> 1];
   endfunction

   function automatic dist_type width_distance(input width_type m);
      if (m == '0)
         return NO_DIST;
      if (m == SMALL_WIDTH)
         return SMALL_DIST;
      if (m < LIMIT_WIDTH)
         return dist_type'(int'(DIST_NUMER) / int'(m) - int'(DIST_OFFSET));
      return FAR_DIST;
   endfunction

   function automatic dist_type record_width(input logic det, input width_type w);
      width_hist[next_slot] = det ? w : '0;
      next_slot = (next_slot == LAST_SLOT) ? '0 : slot_type'(next_slot + 1'b1);
      return width_distance(window_median());
   endfunction

   task automatic send_request(input logic det, input width_type w);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.detected  <= det;
      req_chan.box_width <= w;
      do
         @(posedge clock);
      while (req_chan.ready !== 1'b1);
      expected_distances[exp_wr_count % EXP_DEPTH] = record_width(det, w);
      exp_wr_count++;
      sent_count++;
   endtask

   task automatic release_request();
      @(negedge clock);
      req_chan.valid <= 1'b0;
   endtask

   // receiver: random idling, plus a long hold-off on request
   initial begin
      rsp_chan.ready = 1'b0;
      hold_left      = 0;
      hold_seen      = 0;
      forever begin
         @(negedge clock);
         if (hold_req_count != hold_seen) begin
            hold_left = HOLD_OFF_LEN;
            hold_seen = hold_req_count;
         end
         if (hold_left != 0) begin
            rsp_chan.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin : check_distance
      dist_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (exp_wr_count == exp_rd_count) begin
            $error("distance: expected none, actual %0d", rsp_chan.distance);
            mismatch_count++;
         end else begin
            want = expected_distances[exp_rd_count % EXP_DEPTH];
            exp_rd_count++;
            checked_count++;
            if (rsp_chan.distance !== want) begin
               $error("distance: expected %0d, actual %0d", want, rsp_chan.distance);
               mismatch_count++;
            end
         end
      end
   end

   task automatic test_empty_window();
      send_request(1'b0, 11'd2047);
      send_request(1'b1, 11'd0);
      release_request();
   endtask

   task automatic test_median_one();
      repeat (5) send_request(1'b1, 11'd1);
      release_request();
   endtask

   task automatic test_width_forty();
      repeat (5) send_request(1'b1, SMALL_WIDTH);
      release_request();
   endtask

   task automatic test_division_edge();
      repeat (5) send_request(1'b1, 11'd349);
      repeat (5) send_request(1'b1, LIMIT_WIDTH);
      release_request();
   endtask

   task automatic test_widest_box();
      repeat (2) send_request(1'b1, 11'd2047);
      release_request();
   endtask

   task automatic test_random_widths(input int n);
      int count;
      int base;
      int run_len;
      int w;
      logic det;
      count = 0;
      while (count < n) begin
         if ($urandom_range(99) < 75) begin
            case ($urandom_range(5))
               0: base = $urandom_range(1, 8);
               1: base = int'(SMALL_WIDTH);
               2: base = $urandom_range(9, 120);
               3: base = $urandom_range(300, 400);
               4: base = $urandom_range(351, 2047);
               default: base = $urandom_range(0, 2047);
            endcase
            run_len = $urandom_range(3, 10);
            repeat (run_len) begin
               det = ($urandom_range(9) != 0);
               w   = base;
               if ($urandom_range(1) == 1)
                  w = base + $urandom_range(6) - 3;
               if (w < 0) w = 0;
               if (w > 2047) w = 2047;
               send_request(det, width_type'(w));
            end
            count += run_len;
         end else begin
            if ($urandom_range(3) == 0)
               send_request(1'b1, 11'd0);
            else
               send_request(1'($urandom_range(1)), width_type'($urandom_range(2047)));
            count++;
         end
      end
      release_request();
   endtask

   task automatic test_receiver_hold_off();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      hold_req_count++;
      repeat (20) send_request(1'b1, width_type'($urandom_range(1, 2047)));
      release_request();
   endtask

   initial begin
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.detected  = 1'b0;
      req_chan.box_width = '0;
      req_idle_pct       = 12;
      rsp_idle_pct       = 78;
      next_slot          = '0;
      foreach (width_hist[i]) width_hist[i] = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_window();
      test_median_one();
      test_width_forty();
      test_division_edge();
      test_widest_box();

      test_random_widths(510);
      req_idle_pct = 78;
      rsp_idle_pct = 12;
      test_random_widths(510);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      test_random_widths(510);

      test_receiver_hold_off();

      while (exp_wr_count != exp_rd_count)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests and checked %0d distances", sent_count, checked_count);
      $display("Covered window extremes, three idling mixes and a long receiver hold-off");
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
